>>> rtl/jtt_pkg.sv
// Shared types, codes and defaults for the job timer table.
package jtt_pkg;

	localparam int NUM_SLOTS_DEF  = 16;
	localparam int COUNT_BITS_DEF = 16;
	localparam int MAX_RESULTS    = 16;

	typedef enum logic [1:0] {
		REQ_TICK   = 2'd0,
		REQ_ADD    = 2'd1,
		REQ_CANCEL = 2'd2,
		REQ_REAP   = 2'd3
	} req_t;

	localparam logic [1:0] ST_RUNNING  = 2'd1;
	localparam logic [1:0] ST_CANCELED = 2'd2;
	localparam logic [1:0] ST_OVER     = 2'd3;

	localparam logic [2:0] RC_OK       = 3'd0;
	localparam logic [2:0] RC_INVALID  = 3'd1;
	localparam logic [2:0] RC_NOSPACE  = 3'd2;
	localparam logic [2:0] RC_OVER     = 3'd3;
	localparam logic [2:0] RC_CANCELED = 3'd4;
	localparam logic [2:0] RC_PERIODIC = 3'd5;
	localparam logic [2:0] RC_RUNNING  = 3'd6;

	typedef enum logic [2:0] {
		S_IDLE,
		S_TICK,
		S_ADD,
		S_CHECK,
		S_EVAL,
		S_FLUSH
	} state_t;

	typedef struct packed {
		logic accept;
		logic tick_adv;
		logic add_step;
		logic cmd_check;
		logic cmd_eval;
		logic flush;
	} cmd_t;

	typedef struct packed {
		logic tick_stall;
		logic tick_done;
		logic add_done;
		logic cmd_invalid;
		logic pend_valid;
		logic out_free;
	} sts_t;

endpackage

>>> rtl/jtt_ctrl.sv
// Request sequencer for the job timer table.
module jtt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_valid,
	input  jtt_pkg::req_t s_req,
	output logic          s_ready,
	input  jtt_pkg::sts_t sts,
	output jtt_pkg::cmd_t cmd
);
	import jtt_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		s_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_ready = 1'b1;
				if (s_valid) begin
					cmd.accept = 1'b1;
					unique case (s_req)
						REQ_TICK: state_d = S_TICK;
						REQ_ADD:  state_d = S_ADD;
						default:  state_d = S_CHECK;
					endcase
				end
			end
			S_TICK: begin
				if (sts.tick_done) begin
					state_d = S_FLUSH;
				end else if (!sts.tick_stall) begin
					cmd.tick_adv = 1'b1;
				end
			end
			S_ADD: begin
				cmd.add_step = 1'b1;
				if (sts.add_done) begin
					state_d = S_FLUSH;
				end
			end
			S_CHECK: begin
				cmd.cmd_check = 1'b1;
				state_d = sts.cmd_invalid ? S_FLUSH : S_EVAL;
			end
			S_EVAL: begin
				cmd.cmd_eval = 1'b1;
				state_d = S_FLUSH;
			end
			S_FLUSH: begin
				// A tick on which nothing fired leaves nothing to send.
				if (!sts.pend_valid) begin
					state_d = S_IDLE;
				end else if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

>>> rtl/jtt_dpath.sv
// Slot storage, scan pipeline and result registers of the job timer table.
module jtt_dpath #(
	parameter int NUM_SLOTS  = jtt_pkg::NUM_SLOTS_DEF,
	parameter int COUNT_BITS = jtt_pkg::COUNT_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  jtt_pkg::cmd_t cmd,
	output jtt_pkg::sts_t sts,
	input  jtt_pkg::req_t s_req,
	input  logic [15:0]   s_period,
	input  logic          s_rep,
	input  logic [7:0]    s_id,
	input  logic          m_ready,
	output logic          m_valid,
	output logic [2:0]    m_code,
	output logic [7:0]    m_slot,
	output logic          m_fired,
	output logic          m_last
);
	import jtt_pkg::*;

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int N_W   = $clog2(MAX_RESULTS + 1);

	// Per-slot storage; in-use flags are flip-flops, the rest is a memory.
	logic [NUM_SLOTS-1:0]  in_use_q;
	logic [1:0]            status_mem [NUM_SLOTS];
	logic [COUNT_BITS-1:0] reload_mem [NUM_SLOTS];
	logic [COUNT_BITS-1:0] ticks_mem  [NUM_SLOTS];
	logic                  rep_mem    [NUM_SLOTS];

	logic [1:0]            rd_status_q;
	logic [COUNT_BITS-1:0] rd_reload_q;
	logic [COUNT_BITS-1:0] rd_ticks_q;
	logic                  rd_rep_q;

	req_t                  req_q;
	logic [COUNT_BITS-1:0] period_q;
	logic                  rep_q;
	logic [7:0]            id_q;

	logic [IDX_W-1:0] idx_q;
	logic             rd_more_q;
	logic             ev_valid_q;
	logic [IDX_W-1:0] ev_idx_q;
	logic [N_W-1:0]   n_q;

	logic       pend_valid_q;
	logic [2:0] pend_code_q;
	logic [7:0] pend_slot_q;
	logic       pend_fired_q;

	logic       out_valid_q;
	logic [2:0] out_code_q;
	logic [7:0] out_slot_q;
	logic       out_fired_q;
	logic       out_last_q;

	logic                  idx_last, idx_free, id_ok, cmd_invalid, out_free;
	logic [IDX_W-1:0]      id_idx;
	logic                  ev_active, ev_fire, ev_report, tick_stall, out_load;
	logic [COUNT_BITS-1:0] ev_dec;
	logic                  rd_en;
	logic [IDX_W-1:0]      raddr, waddr;
	logic                  we_status, we_ticks, we_cfg;
	logic [1:0]            w_status;
	logic [COUNT_BITS-1:0] w_ticks;
	logic                  pend_ld;
	logic [2:0]            pend_code_d;
	logic [7:0]            pend_slot_d;
	logic                  pend_fired_d;
	logic                  reap_free;

	always_comb begin
		idx_last    = (idx_q == IDX_W'(NUM_SLOTS - 1));
		idx_free    = !in_use_q[idx_q];
		id_idx      = id_q[IDX_W-1:0];
		id_ok       = ({1'b0, id_q} < 9'(NUM_SLOTS));
		cmd_invalid = !id_ok || !in_use_q[id_idx];
		out_free    = !out_valid_q || m_ready;

		ev_dec     = rd_ticks_q - COUNT_BITS'(1);
		ev_active  = in_use_q[ev_idx_q] && (rd_status_q == ST_RUNNING) && (rd_ticks_q != '0);
		ev_fire    = ev_valid_q && ev_active && (ev_dec == '0);
		// Firings past the per-tick limit still update the slot but are not reported.
		ev_report  = ev_fire && (n_q < N_W'(MAX_RESULTS));
		tick_stall = ev_report && pend_valid_q && !out_free;
		out_load   = (cmd.tick_adv && ev_report && pend_valid_q) || cmd.flush;

		rd_en = (cmd.tick_adv && rd_more_q) || (cmd.cmd_check && !cmd_invalid);
		raddr = cmd.cmd_check ? id_idx : idx_q;

		reap_free = !rd_rep_q && (rd_status_q != ST_RUNNING);
	end

	always_comb begin
		we_status = 1'b0;
		we_ticks  = 1'b0;
		we_cfg    = 1'b0;
		waddr     = ev_idx_q;
		w_status  = ST_RUNNING;
		w_ticks   = ev_dec;
		priority if (cmd.tick_adv && ev_valid_q && ev_active) begin
			we_ticks = 1'b1;
			if (ev_dec == '0) begin
				if (rd_rep_q) begin
					w_ticks = rd_reload_q;
				end else begin
					we_status = 1'b1;
					w_status  = ST_OVER;
				end
			end
		end else if (cmd.add_step && idx_free) begin
			waddr     = idx_q;
			we_status = 1'b1;
			we_ticks  = 1'b1;
			we_cfg    = 1'b1;
			w_status  = ST_RUNNING;
			w_ticks   = period_q;
		end else if (cmd.cmd_eval && req_q == REQ_CANCEL && rd_status_q != ST_OVER
				&& rd_status_q != ST_CANCELED) begin
			waddr     = id_idx;
			we_status = 1'b1;
			w_status  = ST_CANCELED;
		end else begin
			we_status = 1'b0;
		end
	end

	always_comb begin
		pend_ld      = 1'b0;
		pend_code_d  = RC_OK;
		pend_slot_d  = 8'(id_q);
		pend_fired_d = 1'b0;
		priority if (cmd.tick_adv && ev_report) begin
			pend_ld      = 1'b1;
			pend_slot_d  = 8'(ev_idx_q);
			pend_fired_d = 1'b1;
		end else if (cmd.add_step && (idx_free || idx_last)) begin
			pend_ld     = 1'b1;
			pend_code_d = idx_free ? RC_OK : RC_NOSPACE;
			pend_slot_d = idx_free ? 8'(idx_q) : 8'd0;
		end else if (cmd.cmd_check && cmd_invalid) begin
			pend_ld     = 1'b1;
			pend_code_d = RC_INVALID;
		end else if (cmd.cmd_eval) begin
			pend_ld = 1'b1;
			if (req_q == REQ_CANCEL) begin
				priority if (rd_status_q == ST_OVER) begin
					pend_code_d = RC_OVER;
				end else if (rd_status_q == ST_CANCELED) begin
					pend_code_d = RC_CANCELED;
				end else begin
					pend_code_d = RC_OK;
				end
			end else begin
				priority if (rd_rep_q) begin
					pend_code_d = RC_PERIODIC;
				end else if (rd_status_q == ST_RUNNING) begin
					pend_code_d = RC_RUNNING;
				end else begin
					pend_code_d = RC_OK;
				end
			end
		end else begin
			pend_ld = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (we_status) begin
			status_mem[waddr] <= w_status;
		end
		if (we_ticks) begin
			ticks_mem[waddr] <= w_ticks;
		end
		if (we_cfg) begin
			reload_mem[waddr] <= period_q;
			rep_mem[waddr]    <= rep_q;
		end
		if (rd_en) begin
			rd_status_q <= status_mem[raddr];
			rd_reload_q <= reload_mem[raddr];
			rd_ticks_q  <= ticks_mem[raddr];
			rd_rep_q    <= rep_mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q    <= s_req;
			period_q <= COUNT_BITS'(s_period);
			rep_q    <= s_rep;
			id_q     <= s_id;
		end
		if (cmd.tick_adv && rd_more_q) begin
			ev_idx_q <= idx_q;
		end
		if (pend_ld) begin
			pend_code_q  <= pend_code_d;
			pend_slot_q  <= pend_slot_d;
			pend_fired_q <= pend_fired_d;
		end
		if (out_load) begin
			out_code_q  <= pend_code_q;
			out_slot_q  <= pend_slot_q;
			out_fired_q <= pend_fired_q;
			out_last_q  <= cmd.flush;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q     <= '0;
			idx_q        <= '0;
			rd_more_q    <= 1'b0;
			ev_valid_q   <= 1'b0;
			n_q          <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.accept) begin
				idx_q      <= '0;
				rd_more_q  <= 1'b1;
				ev_valid_q <= 1'b0;
				n_q        <= '0;
			end else if (cmd.tick_adv) begin
				ev_valid_q <= rd_more_q;
				if (rd_more_q) begin
					if (idx_last) begin
						rd_more_q <= 1'b0;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				if (ev_report) begin
					n_q <= n_q + N_W'(1);
				end
			end else if (cmd.add_step && !idx_free && !idx_last) begin
				idx_q <= idx_q + IDX_W'(1);
			end

			if (cmd.add_step && idx_free) begin
				in_use_q[idx_q] <= 1'b1;
			end else if (cmd.cmd_eval && req_q == REQ_REAP && reap_free) begin
				in_use_q[id_idx] <= 1'b0;
			end

			if (pend_ld) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.tick_stall  = tick_stall;
		sts.tick_done   = !rd_more_q && !ev_valid_q;
		sts.add_done    = idx_free || idx_last;
		sts.cmd_invalid = cmd_invalid;
		sts.pend_valid  = pend_valid_q;
		sts.out_free    = out_free;
	end

	assign m_valid = out_valid_q;
	assign m_code  = out_code_q;
	assign m_slot  = out_slot_q;
	assign m_fired = out_fired_q;
	assign m_last  = out_last_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free) else $error("result register overwritten while full");
	a_clean_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> (!pend_valid_q && !ev_valid_q))
		else $error("new request accepted with work left over");
	a_report_cap: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= N_W'(MAX_RESULTS)) else $error("too many firings reported");
	a_adv_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tick_adv |-> !tick_stall) else $error("tick scan advanced during stall");

endmodule

>>> rtl/job_timer_table.sv
// Top level of the job timer table: stream ports, sequencer and slot datapath.
// A tick scans one slot per cycle through the slot memory read port, pausing while
// a firing waits for the result output to be free.
// An add searches the in-use flags one slot per cycle.
// A new request is taken only when idle.
// Reset clears all slots to free; no clearing pass is needed after reset.
module job_timer_table #(
	parameter int NUM_SLOTS  = jtt_pkg::NUM_SLOTS_DEF,
	parameter int COUNT_BITS = jtt_pkg::COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // period_ticks[15:0], repeat_mode[16], slot_id[24:17]
	input  logic [1:0]  s_tuser,  // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // status_code[2:0], result_slot[10:3]
	output logic        m_tuser,  // fired[0]
	output logic        m_tlast
);
	import jtt_pkg::*;

	cmd_t       cmd;
	sts_t       sts;
	logic [2:0] code;
	logic [7:0] slot;

	jtt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_tvalid),
		.s_req   (req_t'(s_tuser)),
		.s_ready (s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	jtt_dpath #(
		.NUM_SLOTS  (NUM_SLOTS),
		.COUNT_BITS (COUNT_BITS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_req    (req_t'(s_tuser)),
		.s_period (s_tdata[15:0]),
		.s_rep    (s_tdata[16]),
		.s_id     (s_tdata[24:17]),
		.m_ready  (m_tready),
		.m_valid  (m_tvalid),
		.m_code   (code),
		.m_slot   (slot),
		.m_fired  (m_tuser),
		.m_last   (m_tlast)
	);

	assign m_tdata = {5'd0, slot, code};

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the job timer table: directed and random requests.
`timescale 1ns / 1ps

module testbench;
	import jtt_pkg::*;

	localparam int SLOTS       = NUM_SLOTS_DEF;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic [2:0] code;
		logic [7:0] slot;
		logic       fired;
		logic       last;
	} timer_result_t;

	// Tracks the slot table and the replies it owes, and checks replies as they arrive.
	class timer_table_scoreboard;
		bit            in_use [SLOTS];
		bit [1:0]      status [SLOTS];
		bit [15:0]     reload [SLOTS];
		bit [15:0]     left   [SLOTS];
		bit            rpt    [SLOTS];
		timer_result_t due_results[$];
		int            errors;
		int            checked;
		int            fired_seen;
		int            full_seen;

		function void push_result(logic [2:0] code, logic [7:0] slot, logic fired, logic last);
			timer_result_t r;
			r.code  = code;
			r.slot  = slot;
			r.fired = fired;
			r.last  = last;
			due_results.push_back(r);
		endfunction

		// Applies one accepted request to the slot table and queues its replies.
		function void apply_request(req_t op, logic [15:0] period, logic rep, logic [7:0] id);
			int n;
			int i;
			logic [2:0] code;
			n = 0;
			case (op)
				REQ_TICK: begin
					for (i = 0; i < SLOTS; i++) begin
						if (in_use[i] && status[i] == ST_RUNNING && left[i] != 0) begin
							left[i] = left[i] - 16'd1;
							if (left[i] == 0) begin
								if (rpt[i])
									left[i] = reload[i];
								else
									status[i] = ST_OVER;
								// Expiries past the reply limit still update the slot.
								if (n < MAX_RESULTS) begin
									push_result(RC_OK, i[7:0], 1'b1, 1'b0);
									n++;
								end
							end
						end
					end
					if (n > 0)
						due_results[$].last = 1'b1;
				end
				REQ_ADD: begin
					for (i = 0; i < SLOTS; i++)
						if (!in_use[i])
							break;
					if (i >= SLOTS) begin
						push_result(RC_NOSPACE, 8'd0, 1'b0, 1'b1);
					end else begin
						status[i] = ST_RUNNING;
						reload[i] = period;
						left[i]   = period;
						rpt[i]    = rep;
						in_use[i] = 1'b1;
						push_result(RC_OK, i[7:0], 1'b0, 1'b1);
					end
				end
				default: begin
					if (id >= SLOTS || !in_use[id]) begin
						code = RC_INVALID;
					end else if (op == REQ_CANCEL) begin
						if (status[id] == ST_OVER) begin
							code = RC_OVER;
						end else if (status[id] == ST_CANCELED) begin
							code = RC_CANCELED;
						end else begin
							status[id] = ST_CANCELED;
							code = RC_OK;
						end
					end else if (rpt[id]) begin
						code = RC_PERIODIC;
					end else if (status[id] == ST_RUNNING) begin
						code = RC_RUNNING;
					end else begin
						in_use[id] = 1'b0;
						code = RC_OK;
					end
					push_result(code, id, 1'b0, 1'b1);
				end
			endcase
		endfunction

		function void check_result(logic [2:0] code, logic [7:0] slot, logic fired, logic last);
			timer_result_t exp_r;
			if (due_results.size() == 0) begin
				$display("%0t: unexpected reply code=%0d slot=%0d fired=%0b last=%0b",
					$time, code, slot, fired, last);
				errors++;
			end else begin
				exp_r = due_results.pop_front();
				checked++;
				if (fired)
					fired_seen++;
				if (code == RC_NOSPACE)
					full_seen++;
				if (code !== exp_r.code) begin
					$display("%0t: status_code expected %0d, got %0d", $time, exp_r.code, code);
					errors++;
				end
				if (slot !== exp_r.slot) begin
					$display("%0t: result_slot expected %0d, got %0d", $time, exp_r.slot, slot);
					errors++;
				end
				if (fired !== exp_r.fired) begin
					$display("%0t: fired expected %0b, got %0b", $time, exp_r.fired, fired);
					errors++;
				end
				if (last !== exp_r.last) begin
					$display("%0t: last_result expected %0b, got %0b", $time, exp_r.last, last);
					errors++;
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;  // period_ticks[15:0], repeat_mode[16], slot_id[24:17]
	logic [1:0]  s_tuser;  // req_type[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;  // status_code[2:0], result_slot[10:3]
	logic        m_tuser;  // fired[0]
	logic        m_tlast;

	timer_table_scoreboard sb;
	bit                    quiet_gaps;
	int                    requests_sent;
	longint                cycles;

	job_timer_table i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Mostly short gaps, now and then a long one, none at all during quiet stretches.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet_gaps || r < 45)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic put_req(req_t op, logic [15:0] period, logic rep, logic [7:0] id);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_tvalid = 1'b0;
			repeat (g) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = op;
		s_tdata  = {7'd0, id, rep, period};
		do @(posedge clk); while (!s_tready);
		sb.apply_request(op, period, rep, id);
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic tick();
		put_req(REQ_TICK, 16'($urandom), 1'($urandom), 8'($urandom));
	endtask

	task automatic run_random(int count);
		int k;
		int r;
		int pick;
		int used[$];
		req_t op;
		logic [15:0] period;
		logic rep;
		logic [7:0] id;
		for (k = 0; k < count; k++) begin
			if ($urandom_range(0, 19) == 0)
				quiet_gaps = ~quiet_gaps;
			r = $urandom_range(0, 99);
			if (r < 40)
				op = REQ_TICK;
			else if (r < 65)
				op = REQ_ADD;
			else if (r < 80)
				op = REQ_CANCEL;
			else
				op = REQ_REAP;
			pick = $urandom_range(0, 99);
			if (pick < 60)
				period = 16'($urandom_range(1, 4));
			else if (pick < 75)
				period = 16'd0;
			else if (pick < 85)
				period = 16'($urandom_range(5, 40));
			else
				period = 16'($urandom_range(0, 65535));
			// Repeating slots can never be freed, so keep them rare.
			rep = ($urandom_range(0, 9) == 0);
			used.delete();
			for (int i = 0; i < SLOTS; i++)
				if (sb.in_use[i])
					used.push_back(i);
			pick = $urandom_range(0, 99);
			if (pick < 75 && used.size() > 0)
				id = 8'(used[$urandom_range(0, used.size() - 1)]);
			else if (pick < 90)
				id = 8'($urandom_range(0, SLOTS - 1));
			else
				id = 8'($urandom_range(0, 255));
			put_req(op, period, rep, id);
		end
		quiet_gaps = 1'b0;
	endtask

	// Output side: runs of ready cycles separated by stalls of random length.
	initial begin
		int ready_left;
		int stall_left;
		ready_left = 0;
		stall_left = 0;
		m_tready   = 1'b0;
		forever begin
			@(negedge clk);
			if (ready_left > 0) begin
				m_tready = 1'b1;
				ready_left--;
			end else if (stall_left > 0) begin
				m_tready = 1'b0;
				stall_left--;
			end else begin
				ready_left = $urandom_range(1, 12);
				stall_left = gap_len();
			end
		end
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata[2:0], m_tdata[10:3], m_tuser, m_tlast);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d replies outstanding",
				cycles, sb.due_results.size());
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		sb            = new;
		cycles        = 0;
		requests_sent = 0;
		quiet_gaps    = 1'b0;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = 32'd0;
		s_tuser       = REQ_TICK;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: bad slots on an empty table, a quiet tick, then one slot of each kind.
		put_req(REQ_REAP, 16'd0, 1'b0, 8'd0);
		put_req(REQ_CANCEL, 16'hFFFF, 1'b1, 8'd255);
		tick();
		put_req(REQ_ADD, 16'd0, 1'b0, 8'd0);        // zero period: runs but never expires
		put_req(REQ_ADD, 16'd1, 1'b0, 8'd0);
		put_req(REQ_ADD, 16'd2, 1'b1, 8'd0);
		put_req(REQ_ADD, 16'hFFFF, 1'b1, 8'hFF);
		tick();
		tick();
		put_req(REQ_CANCEL, 16'd0, 1'b0, 8'd1);     // one-shot already over
		put_req(REQ_REAP, 16'd0, 1'b0, 8'd0);       // still running
		put_req(REQ_CANCEL, 16'd0, 1'b0, 8'd0);
		put_req(REQ_CANCEL, 16'd0, 1'b0, 8'd0);     // already canceled
		put_req(REQ_REAP, 16'd0, 1'b0, 8'd0);
		put_req(REQ_REAP, 16'd0, 1'b0, 8'd2);       // repeating slot is refused
		put_req(REQ_REAP, 16'd0, 1'b0, 8'd1);
		put_req(REQ_CANCEL, 16'd0, 1'b0, 8'(SLOTS));
		put_req(REQ_ADD, 16'd1, 1'b0, 8'd0);
		put_req(REQ_ADD, 16'd1, 1'b0, 8'd0);
		put_req(REQ_ADD, 16'd2, 1'b0, 8'd0);
		tick();                                     // several slots expire together
		tick();

		// Hold the input off until every reply of the directed part is back.
		s_tvalid = 1'b0;
		while (sb.due_results.size() != 0)
			@(negedge clk);
		repeat (SLOTS + 6) @(negedge clk);

		run_random(75);

		// Fill the table past full, tick it, then cancel and reap every slot.
		repeat (SLOTS + 2)
			put_req(REQ_ADD, 16'($urandom_range(1, 8)), 1'b0, 8'($urandom));
		repeat (4)
			tick();
		for (int i = 0; i < SLOTS; i++)
			put_req(REQ_CANCEL, 16'd0, 1'b0, 8'(i));
		for (int i = 0; i < SLOTS; i++)
			put_req(REQ_REAP, 16'd0, 1'b0, 8'(i));
		s_tvalid = 1'b0;

		while (sb.due_results.size() != 0)
			@(posedge clk);
		repeat (2 * SLOTS + 10) @(posedge clk);

		$display("Sent %0d requests; checked %0d replies, %0d of them timer expiries",
			requests_sent, sb.checked, sb.fired_seen);
		$display("and %0d table-full replies; %0d mismatches.", sb.full_seen, sb.errors);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
